FILE: design/landing_gear_sequencer_core_defines.svh
// Assertion macros shared by the landing gear sequencer RTL.
// In synthesis builds the macros expand to nothing.
`ifndef LANDING_GEAR_SEQUENCER_CORE_DEFINES_SVH
`define LANDING_GEAR_SEQUENCER_CORE_DEFINES_SVH

`ifndef SYNTHESIS

// Same-cycle implication, checked at every rising edge outside reset.
`define LGS_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("landing gear sequencer check failed");

// Next-cycle implication, checked at every rising edge outside reset.
`define LGS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("landing gear sequencer check failed");

`else

`define LGS_ASSERT_NOW(label, ante, cons)
`define LGS_ASSERT_NEXT(label, ante, cons)

`endif

`endif

FILE: design/lgs_pkg.sv
`timescale 1ns / 1ps

package lgs_pkg;

    localparam int unsigned CFG_ADDR_W = 5;

    // Configuration register indexes (byte address is four times the index).
    localparam logic [2:0] REG_GEAR_FB_UP  = 3'd0;
    localparam logic [2:0] REG_PHASE_TICKS = 3'd1;
    localparam logic [2:0] REG_PULSE_MIN   = 3'd2;
    localparam logic [2:0] REG_PULSE_MAX   = 3'd3;
    localparam logic [2:0] REG_PULSE_MID   = 3'd4;
    localparam logic [2:0] REG_PRESS_HIGH  = 3'd5;
    localparam logic [2:0] REG_PRESS_LOW   = 3'd6;

    localparam logic [15:0] PHASE_TICKS_RST = 16'd10000;
    localparam logic [11:0] PULSE_MIN_RST   = 12'd800;
    localparam logic [11:0] PULSE_MAX_RST   = 12'd2200;
    localparam logic [11:0] PULSE_MID_RST   = 12'd1500;
    localparam logic [11:0] PRESS_HIGH_RST  = 12'd1000;
    localparam logic [11:0] PRESS_LOW_RST   = 12'd300;

    localparam logic [2:0] ALL_SW = 3'b111;

    typedef enum logic [2:0] {
        PH_IDLE = 3'b001,
        PH_OPEN = 3'b010,
        PH_MOVE = 3'b100
    } phase_t;

    typedef struct packed {
        logic        gear_feedback_up;
        logic [15:0] phase_ticks;
        logic [11:0] pulse_min;
        logic [11:0] pulse_max;
        logic [11:0] pulse_mid;
        logic [11:0] press_high;
        logic [11:0] press_low;
    } cfg_t;

    typedef struct packed {
        logic [11:0] ch1_pulse;
        logic [11:0] ch2_pulse;
        logic [11:0] ch3_pulse;
        logic [2:0]  gear_down_sw;
        logic [2:0]  gear_up_sw;
        logic [2:0]  on_land_sw;
        logic [11:0] press_a;
        logic [11:0] press_b;
        logic        startup_ok;
    } in_item_t;

    typedef struct packed {
        logic door_drive;
        logic gear_drive;
        logic down_done;
        logic up_done;
        logic emergency_done;
        logic remote_mode;
    } res_item_t;

    // State touched by the door and gear sequences.
    typedef struct packed {
        phase_t      down_phase;
        phase_t      up_phase;
        logic        door_level;
        logic        gear_level;
        logic [15:0] phase_timer;
    } seq_state_t;

    typedef struct packed {
        seq_state_t st;
        logic       done;
    } seq_res_t;

    // One advance of the extend sequence: open doors, lower gear, wait for lock.
    function automatic seq_res_t extend_seq(seq_state_t s, logic [2:0] down_sw,
                                            logic [15:0] ticks);
        seq_res_t r;
        r.st   = s;
        r.done = 1'b0;
        case (s.down_phase)
            PH_IDLE:
            begin
                r.st.door_level  = 1'b1;
                r.st.down_phase  = PH_OPEN;
                r.st.phase_timer = ticks;
            end
            PH_OPEN:
            begin
                if (s.phase_timer == '0)
                begin
                    r.st.door_level  = 1'b1;
                    r.st.gear_level  = 1'b1;
                    r.st.down_phase  = PH_MOVE;
                    r.st.phase_timer = ticks;
                end
            end
            PH_MOVE:
            begin
                if ((s.phase_timer == '0) || (down_sw == ALL_SW))
                begin
                    r.st.down_phase = PH_IDLE;
                    r.done          = 1'b1;
                end
            end
            default:
            begin
                r.st.down_phase = PH_IDLE;
            end
        endcase
        return r;
    endfunction

    // One advance of the retract sequence: raise gear, close doors, wait for lock.
    function automatic seq_res_t retract_seq(seq_state_t s, logic [2:0] up_sw,
                                             logic [15:0] ticks);
        seq_res_t r;
        r.st   = s;
        r.done = 1'b0;
        case (s.up_phase)
            PH_IDLE:
            begin
                r.st.gear_level  = 1'b0;
                r.st.up_phase    = PH_OPEN;
                r.st.phase_timer = ticks;
            end
            PH_OPEN:
            begin
                if (s.phase_timer == '0)
                begin
                    r.st.door_level  = 1'b0;
                    r.st.gear_level  = 1'b0;
                    r.st.up_phase    = PH_MOVE;
                    r.st.phase_timer = ticks;
                end
            end
            PH_MOVE:
            begin
                if ((s.phase_timer == '0) || (up_sw == ALL_SW))
                begin
                    r.st.up_phase = PH_IDLE;
                    r.done        = 1'b1;
                end
            end
            default:
            begin
                r.st.up_phase = PH_IDLE;
            end
        endcase
        return r;
    endfunction

endpackage

FILE: design/lgs_cfg_regs.sv
`timescale 1ns / 1ps

module lgs_cfg_regs (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [lgs_pkg::CFG_ADDR_W-1:0]  paddr,
    input  logic [31:0]                     pwdata,
    output logic [31:0]                     prdata,
    output lgs_pkg::cfg_t                   cfg
);
    import lgs_pkg::*;

    cfg_t       cfg_reg;
    cfg_t       cfg_next;
    logic [2:0] reg_idx;
    logic       wr_en;

    assign reg_idx = paddr[4:2];
    assign wr_en   = psel & penable & pwrite;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (reg_idx)
                REG_GEAR_FB_UP:  cfg_next.gear_feedback_up = pwdata[0];
                REG_PHASE_TICKS: cfg_next.phase_ticks      = pwdata[15:0];
                REG_PULSE_MIN:   cfg_next.pulse_min        = pwdata[11:0];
                REG_PULSE_MAX:   cfg_next.pulse_max        = pwdata[11:0];
                REG_PULSE_MID:   cfg_next.pulse_mid        = pwdata[11:0];
                REG_PRESS_HIGH:  cfg_next.press_high       = pwdata[11:0];
                REG_PRESS_LOW:   cfg_next.press_low        = pwdata[11:0];
                default:         cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.gear_feedback_up <= 1'b0;
            cfg_reg.phase_ticks      <= PHASE_TICKS_RST;
            cfg_reg.pulse_min        <= PULSE_MIN_RST;
            cfg_reg.pulse_max        <= PULSE_MAX_RST;
            cfg_reg.pulse_mid        <= PULSE_MID_RST;
            cfg_reg.press_high       <= PRESS_HIGH_RST;
            cfg_reg.press_low        <= PRESS_LOW_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    always_comb
    begin
        case (reg_idx)
            REG_GEAR_FB_UP:  prdata = {31'd0, cfg_reg.gear_feedback_up};
            REG_PHASE_TICKS: prdata = {16'd0, cfg_reg.phase_ticks};
            REG_PULSE_MIN:   prdata = {20'd0, cfg_reg.pulse_min};
            REG_PULSE_MAX:   prdata = {20'd0, cfg_reg.pulse_max};
            REG_PULSE_MID:   prdata = {20'd0, cfg_reg.pulse_mid};
            REG_PRESS_HIGH:  prdata = {20'd0, cfg_reg.press_high};
            REG_PRESS_LOW:   prdata = {20'd0, cfg_reg.press_low};
            default:         prdata = 32'd0;
        endcase
    end

    assign cfg = cfg_reg;

endmodule

FILE: design/lgs_step.sv
`timescale 1ns / 1ps

module lgs_step (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                fire,
    input  lgs_pkg::cfg_t       cfg,
    input  lgs_pkg::in_item_t   item,
    output lgs_pkg::res_item_t  res
);
    import lgs_pkg::*;

    seq_state_t st_reg, st_next;
    logic       down_busy_reg, down_busy_next;
    logic       up_busy_reg, up_busy_next;
    logic       armed_reg, armed_next;
    logic       remote_reg, remote_next;
    logic       upcmd_reg, upcmd_next;

    seq_state_t st_dec, st_main;
    seq_res_t   ext_r, ret_r, emg_r;
    logic       ok1, ok2, ok3;
    logic       down_done, up_done, emg_done;
    logic       down_go, up_go, emg_go;

    // Timer counts down first, stopping at zero.
    always_comb
    begin
        st_dec = st_reg;
        if (st_reg.phase_timer != '0)
        begin
            st_dec.phase_timer = st_reg.phase_timer - 16'd1;
        end
    end

    assign ok1 = (item.ch1_pulse > cfg.pulse_min) && (item.ch1_pulse < cfg.pulse_max);
    assign ok2 = (item.ch2_pulse > cfg.pulse_min) && (item.ch2_pulse < cfg.pulse_max);
    assign ok3 = (item.ch3_pulse > cfg.pulse_min) && (item.ch3_pulse < cfg.pulse_max);

    assign remote_next = remote_reg | ok1 | ok2 | ok3;
    assign upcmd_next  = ok1 ? (item.ch1_pulse > cfg.pulse_mid) : upcmd_reg;

    assign ext_r = extend_seq(st_dec, item.gear_down_sw, cfg.phase_ticks);
    assign ret_r = retract_seq(st_dec, item.gear_up_sw, cfg.phase_ticks);

    assign down_go = item.startup_ok &
                     (down_busy_reg | (item.gear_down_sw != ALL_SW));
    assign up_go   = item.startup_ok &
                     (up_busy_reg | ((item.on_land_sw == 3'd0) &&
                                     (item.gear_up_sw != ALL_SW)));

    // Command or feedback check path.
    always_comb
    begin
        st_main        = st_dec;
        down_busy_next = down_busy_reg;
        up_busy_next   = up_busy_reg;
        down_done      = 1'b0;
        up_done        = 1'b0;
        if (remote_next)
        begin
            if (upcmd_next)
            begin
                st_main = ret_r.st;
                up_done = ret_r.done;
            end
            else
            begin
                st_main   = ext_r.st;
                down_done = ext_r.done;
            end
        end
        else if (!cfg.gear_feedback_up)
        begin
            if (down_go)
            begin
                st_main        = ext_r.st;
                down_busy_next = ~ext_r.done;
                down_done      = ext_r.done;
            end
        end
        else
        begin
            if (up_go)
            begin
                st_main      = ret_r.st;
                up_busy_next = ~ret_r.done;
                up_done      = ret_r.done;
            end
        end
    end

    // Emergency path advances the retract sequence once more on top of the above.
    assign emg_r = retract_seq(st_main, item.gear_up_sw, cfg.phase_ticks);

    always_comb
    begin
        armed_next = armed_reg | (item.press_a > cfg.press_high) |
                     (item.press_b > cfg.press_high);
        emg_go     = armed_next & ((item.press_a < cfg.press_low) |
                                   (item.press_b < cfg.press_low));
        st_next    = st_main;
        emg_done   = 1'b0;
        if (emg_go)
        begin
            st_next  = emg_r.st;
            emg_done = emg_r.done;
            if (emg_r.done)
            begin
                armed_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg.down_phase  <= PH_IDLE;
            st_reg.up_phase    <= PH_IDLE;
            st_reg.door_level  <= 1'b0;
            st_reg.gear_level  <= 1'b0;
            st_reg.phase_timer <= '0;
            down_busy_reg      <= 1'b0;
            up_busy_reg        <= 1'b0;
            armed_reg          <= 1'b0;
            remote_reg         <= 1'b0;
            upcmd_reg          <= 1'b0;
        end
        else if (fire)
        begin
            st_reg        <= st_next;
            down_busy_reg <= down_busy_next;
            up_busy_reg   <= up_busy_next;
            armed_reg     <= armed_next;
            remote_reg    <= remote_next;
            upcmd_reg     <= upcmd_next;
        end
    end

    assign res.door_drive     = st_next.door_level;
    assign res.gear_drive     = st_next.gear_level;
    assign res.down_done      = down_done;
    assign res.up_done        = up_done;
    assign res.emergency_done = emg_done;
    assign res.remote_mode    = remote_next;

endmodule

FILE: design/landing_gear_sequencer_core.sv
`timescale 1ns / 1ps

// Landing gear sequencer. Each input transaction is one 0.5 ms control tick
// carrying three RC pulse captures, the down-lock, up-lock and weight-on-wheels
// switches, two air pressures and a startup flag; each tick produces exactly one
// output transaction with the door and gear drive levels, the extend, retract
// and emergency completion pulses and the sticky remote-mode flag. The block
// accepts one transaction per clock cycle when the output side keeps up. The
// accepting edge loads the tick into the input register; once the output
// register can take it, the whole tick step (timer, pulse qualification,
// sequences, pressure emergency path) evaluates in one pass into the output
// register. A stalled result holds the next tick in the input register, and
// the input stalls only while both registers are full and the output is
// stalled.
// Configuration registers sit on an APB-style port at byte addresses 0x00 to
// 0x18 and must only be written while no tick is in flight.

module landing_gear_sequencer_core (
    input  logic                            clk,
    input  logic                            rst_n,

    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [lgs_pkg::CFG_ADDR_W-1:0]  paddr,
    input  logic [31:0]                     pwdata,
    output logic [31:0]                     prdata,
    output logic                            pready,

    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic [11:0]                     ch1_pulse,
    input  logic [11:0]                     ch2_pulse,
    input  logic [11:0]                     ch3_pulse,
    input  logic [2:0]                      gear_down_sw,
    input  logic [2:0]                      gear_up_sw,
    input  logic [2:0]                      on_land_sw,
    input  logic [11:0]                     press_a,
    input  logic [11:0]                     press_b,
    input  logic                            startup_ok,

    output logic                            out_valid,
    input  logic                            out_stall,
    output logic                            door_drive,
    output logic                            gear_drive,
    output logic                            down_done,
    output logic                            up_done,
    output logic                            emergency_done,
    output logic                            remote_mode
);
    import lgs_pkg::*;

`include "landing_gear_sequencer_core_defines.svh"

    cfg_t      cfg;
    in_item_t  in_item;
    in_item_t  s1_item_reg;
    logic      s1_valid_reg, s1_valid_next;
    res_item_t step_res;
    res_item_t out_res_reg;
    logic      out_valid_reg, out_valid_next;
    logic      out_ready;
    logic      s1_adv;
    logic      in_acc;

    // The APB port never inserts wait states.
    assign pready = 1'b1;

    lgs_cfg_regs u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .cfg     (cfg)
    );

    assign in_item.ch1_pulse    = ch1_pulse;
    assign in_item.ch2_pulse    = ch2_pulse;
    assign in_item.ch3_pulse    = ch3_pulse;
    assign in_item.gear_down_sw = gear_down_sw;
    assign in_item.gear_up_sw   = gear_up_sw;
    assign in_item.on_land_sw   = on_land_sw;
    assign in_item.press_a      = press_a;
    assign in_item.press_b      = press_b;
    assign in_item.startup_ok   = startup_ok;

    // The output register can take a new result when it is empty or is being
    // drained this cycle. The input register moves into it under the same
    // condition, so a full pipeline keeps flowing one transaction per cycle while the output is not stalled.
    assign out_ready = ~out_valid_reg | ~out_stall;
    assign s1_adv    = s1_valid_reg & out_ready;
    assign in_stall  = s1_valid_reg & ~out_ready;
    assign in_acc    = in_valid & ~in_stall;

    assign s1_valid_next  = in_acc | (s1_valid_reg & ~out_ready);
    assign out_valid_next = s1_adv | (out_valid_reg & out_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers carry no reset; they load only on a transaction.
    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            s1_item_reg <= in_item;
        end
        if (s1_adv)
        begin
            out_res_reg <= step_res;
        end
    end

    // The sequencer state advances exactly when its tick moves to the output.
    lgs_step u_step (
        .clk   (clk),
        .rst_n (rst_n),
        .fire  (s1_adv),
        .cfg   (cfg),
        .item  (s1_item_reg),
        .res   (step_res)
    );

    assign out_valid      = out_valid_reg;
    assign door_drive     = out_res_reg.door_drive;
    assign gear_drive     = out_res_reg.gear_drive;
    assign down_done      = out_res_reg.down_done;
    assign up_done        = out_res_reg.up_done;
    assign emergency_done = out_res_reg.emergency_done;
    assign remote_mode    = out_res_reg.remote_mode;

    // Only one of extend and retract is driven by the command or check path.
    `LGS_ASSERT_NOW(a_done_excl, out_valid_reg, !(out_res_reg.down_done && out_res_reg.up_done))
    // The input side is held back only while a tick waits in the input register.
    `LGS_ASSERT_NOW(a_stall_full, in_stall, s1_valid_reg)
    // A tick leaving the input register always lands in the output register.
    `LGS_ASSERT_NEXT(a_adv_lands, s1_adv, out_valid_reg)

endmodule
